@@ hdl/ovl_pkg.sv @@
// shared constants, codes and types of the ordered value list
`timescale 1ns / 1ps

package ovl_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;
    localparam int ST_W     = 3;
    localparam int MC_W     = 5;
    localparam logic [MC_W-1:0] MC_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] STAT_DONE     = 3'd0;
    localparam logic [ST_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [ST_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] STAT_FOUND    = 3'd4;

    // result of the shared compare unit
    typedef struct packed {
        logic            eq;
        logic [MC_W-1:0] cnt_next;
    } t_cmp_res;

endpackage

@@ hdl/ovl_ram.sv @@
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps

module ovl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ovl_cmp.sv @@
// shared equality compare and saturating match counter step
`timescale 1ns / 1ps

module ovl_cmp
    import ovl_pkg::*;
(
    input  logic [VAL_W-1:0] i_data,
    input  logic [VAL_W-1:0] i_key,
    input  logic [MC_W-1:0]  i_cnt,
    output t_cmp_res         o_res
);

    // compare one stored entry against the key and step the count
    always_comb begin
        o_res.eq       = (i_data == i_key);
        o_res.cnt_next = i_cnt;
        if (o_res.eq && (i_cnt != MC_MAX)) begin
            o_res.cnt_next = i_cnt + MC_W'(1);
        end
    end

endmodule

@@ hdl/ordered_value_list.sv @@
// ordered value list: an insertion-ordered store of signed 32-bit values
// Input channel (s side): one word per command, tuser = command
// (0 insert, 1 delete, 2 search, 3 list), tdata = item_value.
// Output channel (m side): tuser = status, tdata = entry_value and
// match_count, tlast marks the final word of a command.
// Search and delete walk the stored entries through the single memory
// read port, one entry a cycle; delete closes the gap by writing each
// later entry one place down as it streams past the compare unit.
// List reads one entry at a time and gives one word per entry.
// The block takes no new command until the current one has handed its
// final word to the output register, which can hold one word while the
// next command is taken.
// Reset empties the list at once; entry storage is not cleared.
// A stalled receiver holds the output word and pauses the walk of a list.
`timescale 1ns / 1ps

module ordered_value_list
    import ovl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [31:0]      i_s_tdata,   // [31:0] item_value
    input  logic [CMD_W-1:0] i_s_tuser,   // [1:0] command
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [39:0]      o_m_tdata,   // [31:0] entry_value, [36:32] match_count
    output logic [ST_W-1:0]  o_m_tuser,   // [2:0] status
    output logic             o_m_tlast    // last word of the command
);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_LIST_RD = 3'd2;
    localparam logic [2:0] S_LIST_LD = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [VAL_W-1:0]  r_key, n_key;
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic              r_pv, n_pv;
    logic [ADDR_W-1:0] r_pa, n_pa;
    logic              r_hit, n_hit;
    logic [MC_W-1:0]   r_mcnt, n_mcnt;
    logic [ST_W-1:0]   r_res_st, n_res_st;
    logic [MC_W-1:0]   r_res_mc, n_res_mc;

    logic              r_ov;
    logic [ST_W-1:0]   r_o_st;
    logic [VAL_W-1:0]  r_o_val;
    logic [MC_W-1:0]   r_o_mc;
    logic              r_o_last;

    logic              ld;
    logic [ST_W-1:0]   ld_st;
    logic [VAL_W-1:0]  ld_val;
    logic [MC_W-1:0]   ld_mc;
    logic              ld_last;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    t_cmp_res          cmp;
    logic              out_free;
    logic              s_acc;
    logic              scan_last;

    // entry storage
    ovl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared compare unit
    ovl_cmp u_cmp (
        .i_data (ram_rdata),
        .i_key  (r_key),
        .i_cnt  (r_mcnt),
        .o_res  (cmp)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ov || i_m_tready;
    assign scan_last  = r_pv && ((CNT_W'(r_pa) + CNT_W'(1)) == r_count);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_rd     = r_rd;
        n_pv     = r_pv;
        n_pa     = r_pa;
        n_hit    = r_hit;
        n_mcnt   = r_mcnt;
        n_res_st = r_res_st;
        n_res_mc = r_res_mc;
        ld       = 1'b0;
        ld_st    = STAT_DONE;
        ld_val   = '0;
        ld_mc    = '0;
        ld_last  = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = r_count[ADDR_W-1:0];
        ram_wdata = i_s_tdata;
        ram_re    = 1'b0;
        ram_raddr = r_rd[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_cmd    = i_s_tuser;
                    n_key    = i_s_tdata;
                    n_rd     = '0;
                    n_pv     = 1'b0;
                    n_hit    = 1'b0;
                    n_mcnt   = '0;
                    n_res_mc = '0;
                    if (i_s_tuser == CMD_INSERT) begin
                        n_state = S_DONE;
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_res_st = STAT_FULL;
                        end else begin
                            ram_we   = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                            n_res_st = STAT_DONE;
                        end
                    end else if (r_count == '0) begin
                        n_state  = S_DONE;
                        n_res_st = STAT_EMPTY;
                    end else if (i_s_tuser == CMD_LIST) begin
                        n_state = S_LIST_RD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while the previous entry is compared
                if (r_rd < r_count) begin
                    ram_re = 1'b1;
                    n_rd   = r_rd + CNT_W'(1);
                    n_pv   = 1'b1;
                    n_pa   = r_rd[ADDR_W-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    n_mcnt = cmp.cnt_next;
                    n_hit  = r_hit || cmp.eq;
                    // shift later entries down one place after the hit
                    if ((r_cmd == CMD_DELETE) && r_hit) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pa - ADDR_W'(1);
                        ram_wdata = ram_rdata;
                    end
                end
                if (scan_last) begin
                    n_state = S_DONE;
                    n_pv    = 1'b0;
                    if (r_cmd == CMD_SEARCH) begin
                        if (cmp.cnt_next != '0) begin
                            n_res_st = STAT_FOUND;
                            n_res_mc = cmp.cnt_next;
                        end else begin
                            n_res_st = STAT_NOTFOUND;
                        end
                    end else if (r_hit || cmp.eq) begin
                        n_res_st = STAT_DONE;
                        n_count  = r_count - CNT_W'(1);
                    end else begin
                        n_res_st = STAT_NOTFOUND;
                    end
                end
            end
            S_LIST_RD: begin
                ram_re  = 1'b1;
                n_state = S_LIST_LD;
            end
            S_LIST_LD: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_st   = STAT_DONE;
                    ld_val  = ram_rdata;
                    ld_last = ((r_rd + CNT_W'(1)) == r_count);
                    if (ld_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd    = r_rd + CNT_W'(1);
                        n_state = S_LIST_RD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_st   = r_res_st;
                    ld_mc   = r_res_mc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_hit   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_hit   <= n_hit;
            if (ld) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_rd     <= n_rd;
        r_pa     <= n_pa;
        r_mcnt   <= n_mcnt;
        r_res_st <= n_res_st;
        r_res_mc <= n_res_mc;
        if (ld) begin
            r_o_st   <= ld_st;
            r_o_val  <= ld_val;
            r_o_mc   <= ld_mc;
            r_o_last <= ld_last;
        end
    end

    // output word
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b000, r_o_mc, r_o_val};
    assign o_m_tuser  = r_o_st;
    assign o_m_tlast  = r_o_last;

`ifndef SYNTH
    // fill count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // only a list produces words that are not last, and those are done
    a_non_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_o_last) |-> (r_o_st == STAT_DONE))
        else $error("non-final word with a status other than done");

    // a list walk never writes the store
    a_list_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LIST_RD) || (r_state == S_LIST_LD)) |-> !ram_we)
        else $error("store written during list");

    // an accepted insert with room grows the list by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tuser == CMD_INSERT) && (r_count != CNT_W'(CAPACITY)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // a found search always reports a nonzero count
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_o_st == STAT_FOUND)) |-> (r_o_mc != '0))
        else $error("found reported with zero count");
`endif

endmodule

@@ test/tb.sv @@
// testbench of the ordered value list: directed and random commands checked against a shadow list
`timescale 1ns / 1ps

module tb;
    import ovl_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam logic [31:0] V_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] V_MIN       = 32'h8000_0000;
    localparam logic [31:0] V_NEG1      = 32'hFFFF_FFFF;

    // one output word as it should appear on the m side
    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [31:0]     entry_value;
        logic [MC_W-1:0] match_count;
        logic            last;
    } t_list_word;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [31:0]      s_data  = '0;
    logic [CMD_W-1:0] s_user  = CMD_INSERT;
    logic             m_ready = 1'b1;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [39:0]      o_m_tdata;   // [31:0] entry_value, [36:32] match_count
    logic [ST_W-1:0]  o_m_tuser;   // [2:0] status
    logic             o_m_tlast;

    // shadow copy of the stored values, oldest first
    logic [31:0] shadow_list[$];
    t_list_word  expected_words[$];
    int          mismatches = 0;
    bit          gaps_on    = 1'b1;
    bit          stalls_on  = 1'b1;

    ordered_value_list uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void push_word(logic [ST_W-1:0] status, logic [31:0] value,
                                      logic [MC_W-1:0] cnt, logic last);
        t_list_word w;
        w.status      = status;
        w.entry_value = value;
        w.match_count = cnt;
        w.last        = last;
        expected_words.push_back(w);
    endfunction

    // work out the words one command gives and update the shadow list
    function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [31:0] val);
        int              hit_idx;
        logic [MC_W-1:0] hits;
        hit_idx = -1;
        hits    = '0;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_list.size() >= CAPACITY) begin
                    push_word(STAT_FULL, '0, '0, 1'b1);
                end else begin
                    shadow_list.push_back(val);
                    push_word(STAT_DONE, '0, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (shadow_list.size() == 0) begin
                    push_word(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    foreach (shadow_list[i])
                        if (hit_idx < 0 && shadow_list[i] == val) hit_idx = i;
                    if (hit_idx >= 0) begin
                        shadow_list.delete(hit_idx);
                        push_word(STAT_DONE, '0, '0, 1'b1);
                    end else begin
                        push_word(STAT_NOTFOUND, '0, '0, 1'b1);
                    end
                end
            end
            CMD_SEARCH: begin
                if (shadow_list.size() == 0) begin
                    push_word(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    // count saturates at the top of the field
                    foreach (shadow_list[i])
                        if (shadow_list[i] == val && hits != MC_MAX) hits++;
                    if (hits != 0) push_word(STAT_FOUND, '0, hits, 1'b1);
                    else push_word(STAT_NOTFOUND, '0, '0, 1'b1);
                end
            end
            default: begin
                if (shadow_list.size() == 0) begin
                    push_word(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    foreach (shadow_list[i])
                        push_word(STAT_DONE, shadow_list[i], '0,
                                  (i == shadow_list.size() - 1));
                end
            end
        endcase
    endfunction

    // hand one command word to the block, with the odd random gap
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [31:0] val);
        if (gaps_on && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= val;
        s_user  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        apply_command(cmd, val);
    endtask

    // hold off the sender until every expected word is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    // a stored value, a corner value or anything at all
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40 && shadow_list.size() > 0)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        if (r < 70) begin
            case ($urandom_range(6))
                0: return V_MAX;
                1: return V_MIN;
                2: return V_NEG1;
                3: return 32'd0;
                4: return 32'd1;
                5: return 32'hFFFF_FFFE;
                default: return 32'd2;
            endcase
        end
        return $urandom;
    endfunction

    // empty list cases, extremes and the removal of the only entry
    task automatic test_basic();
        send_word(CMD_LIST, 32'd0);
        send_word(CMD_SEARCH, 32'd5);
        send_word(CMD_DELETE, 32'd5);
        send_word(CMD_INSERT, V_MAX);
        send_word(CMD_LIST, V_NEG1);
        send_word(CMD_DELETE, V_MAX);
        send_word(CMD_LIST, 32'd0);
        send_word(CMD_INSERT, V_MIN);
        send_word(CMD_INSERT, 32'd0);
        send_word(CMD_INSERT, V_NEG1);
        send_word(CMD_INSERT, V_MIN);
        send_word(CMD_SEARCH, V_MIN);
        send_word(CMD_SEARCH, 32'd1);
        send_word(CMD_DELETE, 32'd5);
        send_word(CMD_DELETE, V_MIN);
        send_word(CMD_LIST, 32'd0);
        send_word(CMD_SEARCH, V_MIN);
        send_word(CMD_DELETE, V_NEG1);
        send_word(CMD_DELETE, 32'd0);
        send_word(CMD_DELETE, V_MIN);
        send_word(CMD_LIST, 32'd0);
    endtask

    // fill to capacity, insert when full and list the longest run
    task automatic test_full();
        int k;
        k = 0;
        while (shadow_list.size() < CAPACITY) begin
            send_word(CMD_INSERT, (k % 2 == 0) ? 32'd7 : V_MIN + k);
            k++;
        end
        send_word(CMD_INSERT, V_MAX);
        send_word(CMD_INSERT, 32'd7);
        send_word(CMD_SEARCH, 32'd7);
        send_word(CMD_LIST, 32'd0);
        send_word(CMD_DELETE, 32'd7);
        send_word(CMD_DELETE, shadow_list[shadow_list.size() - 1]);
        send_word(CMD_SEARCH, 32'd7);
        send_word(CMD_LIST, 32'd0);
    endtask

    // random mix of commands, inserts weighted down once the list is full
    task automatic test_random(int count);
        int               r;
        int               ins_w;
        logic [CMD_W-1:0] cmd;
        repeat (count) begin
            ins_w = (shadow_list.size() >= CAPACITY) ? 10 : 40;
            r = $urandom_range(ins_w + 54);
            if (r < ins_w) cmd = CMD_INSERT;
            else if (r < ins_w + 25) cmd = CMD_DELETE;
            else if (r < ins_w + 45) cmd = CMD_SEARCH;
            else cmd = CMD_LIST;
            send_word(cmd, pick_value());
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        m_ready <= !stalls_on || ($urandom_range(99) >= 7);
    end

    // compare every accepted output word with the oldest expectation
    always @(posedge i_clk) begin : check_words
        t_list_word want;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word status %0d tdata %h last %b", $time,
                         o_m_tuser, o_m_tdata, o_m_tlast);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (o_m_tuser !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             o_m_tuser);
                    mismatches++;
                end
                if (o_m_tdata[31:0] !== want.entry_value) begin
                    $display("%0t: entry_value expected %h got %h", $time,
                             want.entry_value, o_m_tdata[31:0]);
                    mismatches++;
                end
                if (o_m_tdata[36:32] !== want.match_count) begin
                    $display("%0t: match_count expected %0d got %0d", $time,
                             want.match_count, o_m_tdata[36:32]);
                    mismatches++;
                end
                if (o_m_tdata[39:37] !== 3'd0) begin
                    $display("%0t: tdata padding expected 0 got %b", $time,
                             o_m_tdata[39:37]);
                    mismatches++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last, o_m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // end the run if nothing moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && o_s_tready) || (o_m_tvalid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("[ordered_value_list] ERROR");
        $finish;
    end

    // test sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic();
        test_full();
        test_random(50);
        wait_for_results();
        // stretch with no idling on either side
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random(30);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_random(36);
        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("[ordered_value_list] OK");
        end else begin
            $display("[ordered_value_list] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/ovl_pkg.sv
hdl/ovl_ram.sv
hdl/ovl_cmp.sv
hdl/ordered_value_list.sv
test/tb.sv
